// File: rtl/trb_pkg.sv
// trb_pkg: shared types and codes of the trace ring buffer
// no dependencies; used by the interfaces, the top level, the store, the snapshot sequencer and the checker
`default_nettype none

package trb_pkg;

   localparam int CMD_W    = 2;
   localparam int MAXC_W   = 7;
   localparam int CALC_W   = MAXC_W + 1;
   localparam int SEQ_W    = 32;
   localparam int STAMP_W  = 64;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 4;
   localparam int LABEL_W  = 64;
   localparam int LABEL_MAX_BYTES = LABEL_W / BYTE_W;

   localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SNAP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic [SEQ_W-1:0]   seq;
      logic [STAMP_W-1:0] stamp;
      logic [BYTE_W-1:0]  kind;
      logic [BYTE_W-1:0]  flags;
      logic [LEN_W-1:0]   len;
      logic [LABEL_W-1:0] label;
   } rec_type;

   // control from the top level to the record store
   typedef struct packed {
      logic wr_en;
      logic clr;
   } store_ctl_type;

endpackage

`default_nettype wire

// File: rtl/trb_ifs.sv
// trb_req_if, trb_rsp_if: valid/ready channels of the trace ring buffer
// depends on trb_pkg for field widths
`default_nettype none

interface trb_req_if import trb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      cmd;
   logic [BYTE_W-1:0]     record_kind;
   logic [BYTE_W-1:0]     record_flags;
   logic                  label_present;
   logic [BYTE_W-1:0]     label_length;
   logic [LABEL_W-1:0]    label_bytes;
   logic [STAMP_W-1:0]    time_stamp;
   logic [MAXC_W-1:0]     max_count;

   modport source (output valid, cmd, record_kind, record_flags, label_present,
                   label_length, label_bytes, time_stamp, max_count, input ready);
   modport sink   (input valid, cmd, record_kind, record_flags, label_present,
                   label_length, label_bytes, time_stamp, max_count, output ready);
endinterface

interface trb_rsp_if import trb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  item_valid;
   logic [SEQ_W-1:0]      out_sequence;
   logic [STAMP_W-1:0]    out_time;
   logic [BYTE_W-1:0]     out_kind;
   logic [BYTE_W-1:0]     out_flags;
   logic [LEN_W-1:0]      out_label_length;
   logic [LABEL_W-1:0]    out_label;
   logic                  last_item;

   modport source (output valid, item_valid, out_sequence, out_time, out_kind, out_flags,
                   out_label_length, out_label, last_item, input ready);
   modport sink   (input valid, item_valid, out_sequence, out_time, out_kind, out_flags,
                   out_label_length, out_label, last_item, output ready);
endinterface

`default_nettype wire

// File: rtl/trace_ring_buffer_unit.sv
// trace_ring_buffer_unit: top level of the circular trace store
// depends on trb_pkg, trb_ifs (channels), trb_store and trb_snapshot
//
//   channel | dir | transfer moves                         | results
//   --------+-----+----------------------------------------+------------------------
//   req     | in  | command: push, snapshot or clear       | push/clear: none
//   rsp     | out | one record, or an empty-run marker     | snapshot: 1..DEPTH items
//
// push and clear may follow each other back to back
// a snapshot holds req.ready low until its run ends; the single memory read port delivers
//   one entry per cycle while rsp does not stall, so records leave at one a cycle
// rsp stalls back-pressure the scan: the read port stops and the read data holds
// reset clears counters and per-entry valid bits at once, no clearing pass
// the clear command likewise drops all valid bits at once
`default_nettype none

module trace_ring_buffer_unit import trb_pkg::*; #(
   parameter int DEPTH       = 64,
   parameter int LABEL_BYTES = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   trb_req_if.sink   req_port,
   trb_rsp_if.source rsp_port
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // write head, sequence stamp and fill level
   logic [AW-1:0]    wpos_ff, wpos_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [CW-1:0]    ret_ff, ret_in;

   logic          busy;
   logic          req_xfer;
   logic          do_push, do_snap, do_clear;
   store_ctl_type store_ctl;
   rec_type       push_rec;
   logic [BYTE_W-1:0] len_clamped;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   rec_type       rd_rec;
   logic          rd_vld;

   // no new command while a snapshot run is in progress
   assign req_port.ready = !busy;
   assign req_xfer       = req_port.valid && req_port.ready;

   // the unused command code falls through all three
   assign do_push  = req_xfer && (req_port.cmd == CMD_PUSH);
   assign do_snap  = req_xfer && (req_port.cmd == CMD_SNAP);
   assign do_clear = req_xfer && (req_port.cmd == CMD_CLEAR);

   // label length: zero without a label, else clamped to the label size
   always_comb begin
      if (!req_port.label_present) begin
         len_clamped = '0;
      end else if (req_port.label_length > BYTE_W'(LABEL_BYTES)) begin
         len_clamped = BYTE_W'(LABEL_BYTES);
      end else begin
         len_clamped = req_port.label_length;
      end
   end

   // record as stored: label bytes at or above the length read as zero
   always_comb begin
      push_rec.seq   = seq_ff + 1'b1;
      push_rec.stamp = req_port.time_stamp;
      push_rec.kind  = req_port.record_kind;
      push_rec.flags = req_port.record_flags;
      push_rec.len   = LEN_W'(len_clamped);
      for (int b = 0; b < LABEL_MAX_BYTES; b++) begin
         push_rec.label[b*BYTE_W +: BYTE_W] =
            (BYTE_W'(b) < len_clamped) ? req_port.label_bytes[b*BYTE_W +: BYTE_W] : '0;
      end
   end

   always_comb begin
      store_ctl.wr_en = do_push;
      store_ctl.clr   = do_clear;
   end

   always_comb begin
      wpos_in = wpos_ff;
      seq_in  = seq_ff;
      ret_in  = ret_ff;
      if (do_clear) begin
         wpos_in = '0;
         seq_in  = '0;
         ret_in  = '0;
      end else if (do_push) begin
         wpos_in = (wpos_ff == AW'(DEPTH - 1)) ? '0 : wpos_ff + 1'b1;
         seq_in  = seq_ff + 1'b1;
         if (ret_ff != CW'(DEPTH)) begin
            ret_in = ret_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff <= '0;
         seq_ff  <= '0;
         ret_ff  <= '0;
      end else begin
         wpos_ff <= wpos_in;
         seq_ff  <= seq_in;
         ret_ff  <= ret_in;
      end
   end

   trb_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (store_ctl),
      .wr_addr (wpos_ff),
      .wr_rec  (push_rec),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_rec  (rd_rec),
      .rd_vld  (rd_vld)
   );

   trb_snapshot #(
      .DEPTH (DEPTH)
   ) u_snapshot (
      .clock     (clock),
      .reset     (reset),
      .start     (do_snap),
      .max_count (req_port.max_count),
      .head      (wpos_ff),
      .retained  (ret_ff),
      .busy      (busy),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_rec    (rd_rec),
      .rd_vld    (rd_vld),
      .rsp       (rsp_port)
   );

endmodule

`default_nettype wire

// File: rtl/trb_store.sv
// trb_store: record memory, one write and one registered read port, per-entry valid bits
// depends on trb_pkg (rec_type, store_ctl_type)
`default_nettype none

module trb_store import trb_pkg::*; #(
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire store_ctl_type ctl,
   input  wire logic [AW-1:0] wr_addr,
   input  wire rec_type       wr_rec,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output rec_type            rd_rec,
   output logic               rd_vld
);

   rec_type          mem [DEPTH];
   rec_type          rd_rec_ff;
   logic             rd_vld_ff;
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_rec;
      end
      if (rd_en) begin
         rd_rec_ff <= mem[rd_addr];
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   // entries never written since reset or clear read as empty
   always_comb begin
      vld_in = vld_ff;
      if (ctl.clr) begin
         vld_in = '0;
      end else if (ctl.wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rd_rec = rd_rec_ff;
   assign rd_vld = rd_vld_ff;

endmodule

`default_nettype wire

// File: rtl/trb_snapshot.sv
// trb_snapshot: snapshot sequencer, scans the store oldest first and feeds the result channel
// depends on trb_pkg and trb_rsp_if; reads through the port of trb_store
`default_nettype none

module trb_snapshot import trb_pkg::*; #(
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [MAXC_W-1:0] max_count,
   input  wire logic [AW-1:0]     head,
   input  wire logic [CW-1:0]     retained,
   output logic                   busy,
   output logic                   rd_en,
   output logic [AW-1:0]          rd_addr,
   input  wire rec_type           rd_rec,
   input  wire logic              rd_vld,
   trb_rsp_if.source              rsp
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [CW-1:0] left_ff, left_in;
   logic          d_ff, d_in;
   logic          h_ff, h_in;
   rec_type       h_rec_ff, h_rec_in;
   logic          o_valid_ff, o_valid_in;
   logic          o_item_ff, o_item_in;
   logic          o_last_ff, o_last_in;
   rec_type       o_rec_ff, o_rec_in;

   logic [CALC_W-1:0] cnt_w, ret_w, mc_w, head_w, start_w;
   logic          o_free, d_skip, d_take, move_h, issue, scan_end;

   // window of the newest min(retained, max_count) entries
   always_comb begin
      ret_w   = CALC_W'(retained);
      mc_w    = CALC_W'(max_count);
      head_w  = CALC_W'(head);
      cnt_w   = (ret_w < mc_w) ? ret_w : mc_w;
      start_w = (head_w >= cnt_w) ? head_w - cnt_w : head_w + CALC_W'(DEPTH) - cnt_w;
   end

   always_comb begin
      o_free   = !o_valid_ff || rsp.ready;
      d_skip   = !rd_vld || (rd_rec.seq == '0);
      d_take   = d_ff && (d_skip || !h_ff || o_free);
      move_h   = d_ff && !d_skip && h_ff && o_free;
      issue    = (state_ff == ST_SCAN) && (left_ff != '0) && (!d_ff || d_take);
      scan_end = (state_ff == ST_SCAN) && (left_ff == '0) && !d_ff;
   end

   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      left_in    = left_ff;
      d_in       = d_ff;
      h_in       = h_ff;
      h_rec_in   = h_rec_ff;
      o_valid_in = o_valid_ff && !rsp.ready;
      o_item_in  = o_item_ff;
      o_last_in  = o_last_ff;
      o_rec_in   = o_rec_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
               addr_in  = AW'(start_w);
               left_in  = CW'(cnt_w);
               h_in     = 1'b0;
               d_in     = 1'b0;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               addr_in = (addr_ff == AW'(DEPTH - 1)) ? '0 : addr_ff + 1'b1;
               left_in = left_ff - 1'b1;
            end
            if (issue) begin
               d_in = 1'b1;
            end else if (d_take) begin
               d_in = 1'b0;
            end
            if (move_h) begin
               o_valid_in = 1'b1;
               o_item_in  = 1'b1;
               o_last_in  = 1'b0;
               o_rec_in   = h_rec_ff;
            end
            if (d_take && !d_skip) begin
               h_in     = 1'b1;
               h_rec_in = rd_rec;
            end
            if (scan_end && o_free) begin
               o_valid_in = 1'b1;
               o_last_in  = 1'b1;
               o_item_in  = h_ff;
               o_rec_in   = h_ff ? h_rec_ff : '0;
               h_in       = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         d_ff       <= 1'b0;
         h_ff       <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         d_ff       <= d_in;
         h_ff       <= h_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      left_ff   <= left_in;
      h_rec_ff  <= h_rec_in;
      o_item_ff <= o_item_in;
      o_last_ff <= o_last_in;
      o_rec_ff  <= o_rec_in;
   end

   assign busy    = (state_ff != ST_IDLE);
   assign rd_en   = issue;
   assign rd_addr = addr_ff;

   assign rsp.valid            = o_valid_ff;
   assign rsp.item_valid       = o_item_ff;
   assign rsp.out_sequence     = o_rec_ff.seq;
   assign rsp.out_time         = o_rec_ff.stamp;
   assign rsp.out_kind         = o_rec_ff.kind;
   assign rsp.out_flags        = o_rec_ff.flags;
   assign rsp.out_label_length = o_rec_ff.len;
   assign rsp.out_label        = o_rec_ff.label;
   assign rsp.last_item        = o_last_ff;

endmodule

`default_nettype wire

// File: rtl/trb_checker.sv
// trb_checker: port-level assertions of the trace ring buffer, bound to the top level
// depends on trb_pkg (command codes) and trace_ring_buffer_unit
`default_nettype none

module trb_checker import trb_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic [CMD_W-1:0]   req_cmd,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_item_valid,
   input wire logic [SEQ_W-1:0]   rsp_sequence,
   input wire logic [STAMP_W-1:0] rsp_time,
   input wire logic [LABEL_W-1:0] rsp_label,
   input wire logic               rsp_last_item
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_item_valid, rsp_sequence,
                                  rsp_time, rsp_label, rsp_last_item}))
      else $error("stalled result changed");

   // the empty-run marker ends its run and carries no sequence
   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item_valid |-> rsp_last_item && (rsp_sequence == '0))
      else $error("empty marker malformed");

   // records stamped zero are never returned
   a_no_zero_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_valid |-> (rsp_sequence != '0))
      else $error("record with sequence zero returned");

   // a snapshot keeps req ready low in the cycle after it is taken
   a_snap_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_SNAP) |=> !req_ready)
      else $error("command taken right after snapshot");

endmodule

bind trace_ring_buffer_unit trb_checker u_trb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_port.valid),
   .req_ready      (req_port.ready),
   .req_cmd        (req_port.cmd),
   .rsp_valid      (rsp_port.valid),
   .rsp_ready      (rsp_port.ready),
   .rsp_item_valid (rsp_port.item_valid),
   .rsp_sequence   (rsp_port.out_sequence),
   .rsp_time       (rsp_port.out_time),
   .rsp_label      (rsp_port.out_label),
   .rsp_last_item  (rsp_port.last_item)
);

`default_nettype wire
